/* rtl/rfo_pkg.sv */
package rfo_pkg;

   localparam int CAP_BITS   = 5;
   localparam int COUNT_BITS = 5;
   localparam int DATA_BITS  = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      CMD_ENQUEUE  = 2'd0,
      CMD_DEQUEUE  = 2'd1,
      CMD_PEEK_OLD = 2'd2,
      CMD_PEEK_NEW = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // shared control for the whole row of cells
   typedef struct packed {
      logic shift;
      logic push;
   } cell_ctrl_type;

endpackage

/* rtl/rfo_cell.sv */
module rfo_cell
   import rfo_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int INDEX     = 0,
   parameter int IW        = 4
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [IW-1:0]        slot,
   input  logic [WORD_BITS-1:0] data_in,
   input  logic [WORD_BITS-1:0] data_next,
   output logic [WORD_BITS-1:0] data_q
);

   logic [WORD_BITS-1:0] word_ff;
   logic                 load;

   assign load   = ctrl.push && (slot == IW'(INDEX));
   assign data_q = word_ff;

   // a push into this slot wins over the shift from the neighbor
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= data_in;
      end else if (ctrl.shift) begin
         word_ff <= data_next;
      end
   end

endmodule

/* rtl/ring_fifo_overwrite_core.sv */
// ring_fifo_overwrite_core: command-driven FIFO of words with a programmable
// capacity and optional overwrite of the oldest entry when full.
// req_ channel: one command per transaction (enqueue, dequeue, peek oldest,
//   peek newest) with its data word and overwrite flag.
// rsp_ channel: one result per command: status, data word and the count
//   held after the command.
// csr_ channel: writes the capacity register; each write empties the queue.
// rsp_valid rises in the cycle after a request is accepted. The block takes
// one command every cycle while no result stalls: entries sit oldest first
// in a row of cells that all shift toward the front in the same cycle on a
// dequeue or an overwrite, and a push lands directly in the cell at the fill
// position. The result register frees as it is taken, so a new command is
// accepted in the cycle the previous result is taken. While rsp_stall holds a
// pending result, req_stall is raised and the pending result stays unchanged.
// Reset (synchronous) empties the queue, drops any pending result and sets
// capacity to 16 (clamped to DEPTH). Stored words are not cleared.
module ring_fifo_overwrite_core
   import rfo_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [DATA_BITS-1:0]  req_data_in,
   input  logic                  req_overwrite,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [DATA_BITS-1:0]  rsp_data_out,
   output logic [COUNT_BITS-1:0] rsp_count,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_BITS-1:0]   csr_capacity
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = (CW > CAP_BITS) ? CW : CAP_BITS;

   logic [CAP_BITS-1:0]   cap_ff;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [WORD_BITS-1:0]  newest_ff, newest_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, status_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic                  accept;
   logic                  csr_write;
   logic [EW-1:0]         cap_ext;
   logic [EW-1:0]         cap_clamp;
   logic [CW-1:0]         eff_cap;
   logic                  full;
   logic                  empty;
   command_type           cmd;
   cell_ctrl_type         ctrl;
   cell_ctrl_type         ctrl_req;
   logic [IW-1:0]         slot;
   logic [WORD_BITS-1:0]  word_in;
   logic [DATA_BITS-1:0]  front_out;
   logic [DATA_BITS-1:0]  newest_out;
   logic [WORD_BITS-1:0]  cell_q [DEPTH];

   assign accept    = req_valid && !req_stall;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;
   assign cmd       = command_type'(req_command);

   // capacity 0 acts as 1, above DEPTH acts as DEPTH
   assign cap_ext   = EW'(cap_ff);
   assign cap_clamp = (cap_ext == '0) ? EW'(1) :
                      (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;
   assign eff_cap   = CW'(cap_clamp);
   assign full      = (fill_ff >= eff_cap);
   assign empty     = (fill_ff == '0);

   // port width to word width and back
   generate
      if (WORD_BITS <= DATA_BITS) begin : g_narrow
         assign word_in    = req_data_in[WORD_BITS-1:0];
         assign front_out  = DATA_BITS'(cell_q[0]);
         assign newest_out = DATA_BITS'(newest_ff);
      end else begin : g_wide
         assign word_in    = WORD_BITS'(req_data_in);
         assign front_out  = cell_q[0][DATA_BITS-1:0];
         assign newest_out = newest_ff[DATA_BITS-1:0];
      end
   endgenerate

   always_comb begin
      status_in   = ST_OK;
      rsp_data_in = '0;
      fill_in     = fill_ff;
      newest_in   = newest_ff;
      ctrl_req    = '0;
      case (cmd)
         CMD_ENQUEUE: begin
            if (full) begin
               if (req_overwrite) begin
                  ctrl_req.shift = 1'b1;
                  ctrl_req.push  = 1'b1;
                  newest_in      = word_in;
               end else begin
                  status_in = ST_FULL;
               end
            end else begin
               ctrl_req.push = 1'b1;
               fill_in       = fill_ff + CW'(1);
               newest_in     = word_in;
            end
         end
         CMD_DEQUEUE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rsp_data_in    = front_out;
               ctrl_req.shift = 1'b1;
               fill_in        = fill_ff - CW'(1);
            end
         end
         CMD_PEEK_OLD: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rsp_data_in = front_out;
            end
         end
         CMD_PEEK_NEW: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rsp_data_in = newest_out;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign ctrl.shift = accept && ctrl_req.shift;
   assign ctrl.push  = accept && ctrl_req.push;

   // after a shift the new word goes one below the old fill position
   assign slot = ctrl_req.shift ? IW'(fill_ff - CW'(1)) : IW'(fill_ff);

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [WORD_BITS-1:0] next_word;
         if (i == DEPTH - 1) begin : g_last
            assign next_word = '0;
         end else begin : g_mid
            assign next_word = cell_q[i+1];
         end
         rfo_cell #(
            .WORD_BITS(WORD_BITS),
            .INDEX    (i),
            .IW       (IW)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .slot     (slot),
            .data_in  (word_in),
            .data_next(next_word),
            .data_q   (cell_q[i])
         );
      end
   endgenerate

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            cap_ff  <= csr_capacity;
            fill_ff <= '0;
         end else if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         newest_ff     <= newest_in;
         rsp_status_ff <= status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= COUNT_BITS'(fill_in);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;

`ifndef SYNTHESIS
   a_fill_in_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_cap)
      else $error("fill count above capacity");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_csr_empties: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (fill_ff == '0))
      else $error("capacity write did not empty the queue");

   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_EMPTY)) |-> (rsp_data_ff == '0))
      else $error("empty result carries data");
`endif

endmodule
